@@ sv/wcs_pkg.sv @@
// Shared types and constants for the washing cycle sequencer.
// Used by the top level and by its bound checker; no dependencies.
package wcs_pkg;

  // Register index on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_WASH_MODE    = 2'd0,
    REG_WATER_TARGET = 2'd1,
    REG_DRAIN_COUNT  = 2'd2
  } reg_index_t;

  // Wash mode codes.
  localparam logic [2:0] MODE_NORMAL    = 3'd1;
  localparam logic [2:0] MODE_SOAK      = 3'd2;
  localparam logic [2:0] MODE_QUICK     = 3'd3;
  localparam logic [2:0] MODE_GENTLE    = 3'd4;
  localparam logic [2:0] MODE_SPIN_ONLY = 3'd5;

  // Program step codes as they appear on the result.
  localparam logic [2:0] STEP_IDLE  = 3'd0;
  localparam logic [2:0] STEP_FILL  = 3'd1;
  localparam logic [2:0] STEP_WASH  = 3'd2;
  localparam logic [2:0] STEP_DRAIN = 3'd3;
  localparam logic [2:0] STEP_SPIN  = 3'd4;
  localparam logic [2:0] STEP_BEEP  = 3'd5;

  // Timing in millisecond ticks.
  localparam logic [14:0] WASH_NORMAL_MS = 15'd15000;
  localparam logic [14:0] WASH_SOAK_MS   = 15'd25000;
  localparam logic [14:0] WASH_QUICK_MS  = 15'd10000;
  localparam logic [14:0] SOAK_RUN_MS    = 15'd10000;
  localparam logic [14:0] SOAK_PAUSE_MS  = 15'd15000;
  localparam logic [11:0] REVERSE_MS     = 12'd3000;
  localparam logic [13:0] SPIN_MS        = 14'd10000;
  localparam logic [9:0]  BEEP_HALF_MS   = 10'd800;
  localparam logic [2:0]  BEEP_LAST      = 3'd3;

  localparam logic [7:0]  LEVEL_STEP     = 8'd10;
  localparam logic [6:0]  DRAIN_EMPTY    = 7'd10;
  localparam logic [9:0]  SPEED_FULL     = 10'd1000;
  localparam logic [9:0]  SPEED_GENTLE   = 10'd750;

  typedef struct packed {
    logic       run;
    logic [6:0] tank_level;
  } tick_t;

  typedef struct packed {
    logic        fill_valve;
    logic        drain_valve;
    logic        drain_lamp;
    logic        motor_on;
    logic        motor_reverse;
    logic        buzzer;
    logic [9:0]  speed_scale;
    logic [2:0]  step;
    logic [3:0]  drains_done;
    logic [14:0] wash_left;
    logic        done_res;
  } stat_t;

  function automatic logic [14:0] wash_length(input logic [2:0] mode);
    logic [14:0] len;
    case (mode)
      MODE_SOAK:      len = WASH_SOAK_MS;
      MODE_QUICK:     len = WASH_QUICK_MS;
      MODE_SPIN_ONLY: len = '0;
      default:        len = WASH_NORMAL_MS;
    endcase
    return len;
  endfunction

endpackage

@@ sv/washing_cycle_sequencer_unit.sv @@
// A result is registered when its tick is accepted, via the skid slot if the output stalls.
// Throughput: one tick per clock cycle while tick_stall is low; all per-tick work is one register stage.
// A two-entry output buffer (result register plus skid slot) lets a tick be
// accepted while one result waits; tick_stall is high only when both are full.
// Synchronous active-high rst returns the program to idle, the registers to
// mode 1, target 5, one round, and the held result to its power-on value.
module washing_cycle_sequencer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          tick_valid,
  output logic          tick_stall,
  input  wcs_pkg::tick_t tick,
  output logic          stat_valid,
  input  logic          stat_stall,
  output wcs_pkg::stat_t stat,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import wcs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = STEP_IDLE,
    PH_FILL  = STEP_FILL,
    PH_WASH  = STEP_WASH,
    PH_DRAIN = STEP_DRAIN,
    PH_SPIN  = STEP_SPIN,
    PH_BEEP  = STEP_BEEP
  } phase_t;

  // Configuration registers.
  logic [2:0] wash_mode;
  logic [3:0] water_target;
  logic [3:0] drain_count;

  // Program state.
  phase_t      phase, phase_next;
  logic [14:0] wash_elapsed, wash_elapsed_next;
  logic [11:0] reverse_elapsed, reverse_elapsed_next;
  logic        direction, direction_next;
  logic [3:0]  rounds_done, rounds_done_next;
  logic [13:0] spin_elapsed, spin_elapsed_next;
  logic [9:0]  beep_elapsed, beep_elapsed_next;
  logic        beep_level, beep_level_next;
  logic [2:0]  beeps_sounded, beeps_sounded_next;
  logic        finished, finished_next;

  // Output latches: they hold until a phase drives them.
  logic        fill_valve, fill_valve_next;
  logic        drain_valve, drain_valve_next;
  logic        drain_lamp, drain_lamp_next;
  logic        motor_on, motor_on_next;
  logic        motor_reverse, motor_reverse_next;
  logic        buzzer, buzzer_next;
  logic [9:0]  speed_scale, speed_scale_next;

  // Last result, repeated for ticks with run low.
  stat_t last_res;
  stat_t res_next;

  logic        skid_valid;
  stat_t       skid;
  logic        accept;
  logic        out_take;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  fill_limit;
  logic [14:0] len;
  logic [3:0]  rounds_inc;
  logic        soak_pause;

  assign accept     = tick_valid && !tick_stall;
  assign tick_stall = skid_valid;
  assign out_take   = stat_valid && !stat_stall;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite;
  assign cfg_index  = paddr[3:2];

  assign fill_limit = {4'd0, water_target} * LEVEL_STEP;
  assign len        = wash_length(wash_mode);
  assign rounds_inc = rounds_done + 4'd1;
  // Soak mode stops the drum between the two wash runs.
  assign soak_pause = (wash_mode == MODE_SOAK) && (wash_elapsed >= SOAK_RUN_MS) &&
                      (wash_elapsed <= SOAK_PAUSE_MS);

  always_comb begin
    case (cfg_index)
      REG_WASH_MODE:    prdata = {29'd0, wash_mode};
      REG_WATER_TARGET: prdata = {28'd0, water_target};
      REG_DRAIN_COUNT:  prdata = {28'd0, drain_count};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    wash_elapsed_next    = wash_elapsed;
    reverse_elapsed_next = reverse_elapsed;
    direction_next       = direction;
    rounds_done_next     = rounds_done;
    spin_elapsed_next    = spin_elapsed;
    beep_elapsed_next    = beep_elapsed;
    beep_level_next      = beep_level;
    beeps_sounded_next   = beeps_sounded;
    finished_next        = finished;
    fill_valve_next      = fill_valve;
    drain_valve_next     = drain_valve;
    drain_lamp_next      = drain_lamp;
    motor_on_next        = motor_on;
    motor_reverse_next   = motor_reverse;
    buzzer_next          = buzzer;
    speed_scale_next     = speed_scale;

    case (phase)
      PH_FILL: begin
        if (wash_mode == MODE_SPIN_ONLY) begin
          phase_next = PH_SPIN;
        end else if ({1'b0, tick.tank_level} <= fill_limit) begin
          fill_valve_next = 1'b1;
        end else begin
          fill_valve_next = 1'b0;
          phase_next      = PH_WASH;
        end
      end
      PH_WASH: begin
        if (wash_elapsed < len) begin
          if (!soak_pause) begin
            motor_on_next      = 1'b1;
            motor_reverse_next = direction;
            if (reverse_elapsed > REVERSE_MS) begin
              direction_next       = !direction;
              reverse_elapsed_next = 12'd1;
            end else if (reverse_elapsed != '1) begin
              reverse_elapsed_next = reverse_elapsed + 12'd1;
            end
          end else begin
            motor_on_next = 1'b0;
            if (reverse_elapsed != '1) begin
              reverse_elapsed_next = reverse_elapsed + 12'd1;
            end
          end
          if (wash_elapsed != '1) begin
            wash_elapsed_next = wash_elapsed + 15'd1;
          end
        end else begin
          motor_on_next        = 1'b0;
          wash_elapsed_next    = '0;
          reverse_elapsed_next = '0;
          phase_next           = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        if (tick.tank_level >= DRAIN_EMPTY) begin
          drain_valve_next = 1'b1;
          drain_lamp_next  = 1'b1;
        end else begin
          drain_valve_next = 1'b0;
          drain_lamp_next  = 1'b0;
          if (rounds_inc != drain_count) begin
            rounds_done_next = rounds_inc;
            phase_next       = PH_FILL;
          end else begin
            rounds_done_next = '0;
            phase_next       = PH_SPIN;
          end
        end
      end
      PH_SPIN: begin
        if (spin_elapsed < SPIN_MS) begin
          drain_valve_next   = 1'b1;
          motor_on_next      = 1'b1;
          motor_reverse_next = 1'b1;
          spin_elapsed_next  = spin_elapsed + 14'd1;
        end else begin
          drain_valve_next   = 1'b0;
          motor_on_next      = 1'b0;
          motor_reverse_next = 1'b0;
          spin_elapsed_next  = '0;
          phase_next         = PH_BEEP;
        end
      end
      PH_BEEP: begin
        if (beeps_sounded > BEEP_LAST) begin
          finished_next      = 1'b1;
          buzzer_next        = 1'b0;
          beeps_sounded_next = '0;
          beep_elapsed_next  = '0;
          phase_next         = PH_IDLE;
        end else begin
          buzzer_next = beep_level;
          if (beep_elapsed > BEEP_HALF_MS) begin
            beep_level_next   = !beep_level;
            // A beep is counted on each rising edge of the buzzer level.
            if (!beep_level) begin
              beeps_sounded_next = beeps_sounded + 3'd1;
            end
            beep_elapsed_next = 10'd1;
          end else begin
            beep_elapsed_next = beep_elapsed + 10'd1;
          end
        end
      end
      default: begin
        finished_next    = 1'b0;
        rounds_done_next = '0;
        speed_scale_next = (wash_mode == MODE_GENTLE) ? SPEED_GENTLE : SPEED_FULL;
        phase_next       = PH_FILL;
      end
    endcase

    if (tick.run) begin
      res_next.fill_valve    = fill_valve_next;
      res_next.drain_valve   = drain_valve_next;
      res_next.drain_lamp    = drain_lamp_next;
      res_next.motor_on      = motor_on_next;
      res_next.motor_reverse = motor_reverse_next;
      res_next.buzzer        = buzzer_next;
      res_next.speed_scale   = speed_scale_next;
      res_next.step          = phase_next;
      res_next.drains_done   = rounds_done_next;
      res_next.wash_left     = (len > wash_elapsed_next) ? len - wash_elapsed_next : '0;
      res_next.done_res      = finished_next;
    end else begin
      res_next = last_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wash_mode       <= MODE_NORMAL;
      water_target    <= 4'd5;
      drain_count     <= 4'd1;
      phase           <= PH_IDLE;
      wash_elapsed    <= '0;
      reverse_elapsed <= '0;
      direction       <= 1'b0;
      rounds_done     <= '0;
      spin_elapsed    <= '0;
      beep_elapsed    <= '0;
      beep_level      <= 1'b0;
      beeps_sounded   <= '0;
      finished        <= 1'b0;
      fill_valve      <= 1'b0;
      drain_valve     <= 1'b0;
      drain_lamp      <= 1'b0;
      motor_on        <= 1'b0;
      motor_reverse   <= 1'b0;
      buzzer          <= 1'b0;
      speed_scale     <= SPEED_FULL;
      last_res        <= '{fill_valve: 1'b0, drain_valve: 1'b0, drain_lamp: 1'b0,
                           motor_on: 1'b0, motor_reverse: 1'b0, buzzer: 1'b0,
                           speed_scale: SPEED_FULL, step: STEP_IDLE,
                           drains_done: 4'd0, wash_left: WASH_NORMAL_MS,
                           done_res: 1'b0};
      stat_valid      <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WASH_MODE:    wash_mode    <= pwdata[2:0];
          REG_WATER_TARGET: water_target <= pwdata[3:0];
          REG_DRAIN_COUNT:  drain_count  <= pwdata[3:0];
          default: ;
        endcase
      end

      if (accept && tick.run) begin
        phase           <= phase_next;
        wash_elapsed    <= wash_elapsed_next;
        reverse_elapsed <= reverse_elapsed_next;
        direction       <= direction_next;
        rounds_done     <= rounds_done_next;
        spin_elapsed    <= spin_elapsed_next;
        beep_elapsed    <= beep_elapsed_next;
        beep_level      <= beep_level_next;
        beeps_sounded   <= beeps_sounded_next;
        finished        <= finished_next;
        fill_valve      <= fill_valve_next;
        drain_valve     <= drain_valve_next;
        drain_lamp      <= drain_lamp_next;
        motor_on        <= motor_on_next;
        motor_reverse   <= motor_reverse_next;
        buzzer          <= buzzer_next;
        speed_scale     <= speed_scale_next;
        last_res        <= res_next;
      end

      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (stat_valid && stat_stall) begin
          skid_valid <= 1'b1;
        end else begin
          stat_valid <= 1'b1;
        end
      end else if (out_take) begin
        stat_valid <= 1'b0;
      end
    end
  end

  // Payload side of the output buffer; no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        stat <= skid;
      end
    end else if (accept) begin
      if (stat_valid && stat_stall) begin
        skid <= res_next;
      end else begin
        stat <= res_next;
      end
    end
  end

endmodule

@@ sv/wcs_checker.sv @@
// Port-level checker for the washing cycle sequencer, bound to the top level.
// Depends on wcs_pkg for the result type and step codes.
module wcs_checker (
  input logic           clk,
  input logic           rst,
  input logic           tick_valid,
  input logic           tick_stall,
  input wcs_pkg::tick_t tick,
  input logic           stat_valid,
  input logic           stat_stall,
  input wcs_pkg::stat_t stat
);
  import wcs_pkg::*;

  // A stalled tick transaction keeps its payload until it is taken.
  a_tick_hold: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_stall |=> tick_valid && $stable(tick))
    else $error("tick changed while stalled");

  // A stalled result transaction must hold its payload.
  a_stat_hold: assert property (@(posedge clk) disable iff (rst)
    stat_valid && stat_stall |=> stat_valid && $stable(stat))
    else $error("result changed while stalled");

  // The finished flag is only seen once the program is back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    stat_valid && stat.done_res |-> stat.step == STEP_IDLE)
    else $error("done reported outside idle");

  // While spinning with the motor on, the drain is open and the relay is set.
  a_spin_drive: assert property (@(posedge clk) disable iff (rst)
    stat_valid && stat.step == STEP_SPIN && stat.motor_on |->
      stat.drain_valve && stat.motor_reverse)
    else $error("spin without drain or relay");

  // The buzzer sounds only during the end beeps.
  a_buzzer_beep: assert property (@(posedge clk) disable iff (rst)
    stat_valid && stat.buzzer |-> stat.step == STEP_BEEP)
    else $error("buzzer on outside beep step");

endmodule

bind washing_cycle_sequencer_unit wcs_checker u_wcs_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick_valid),
  .tick_stall (tick_stall),
  .tick       (tick),
  .stat_valid (stat_valid),
  .stat_stall (stat_stall),
  .stat       (stat)
);
